[hdl/ring_byte_buffer_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the ring byte buffer core
// ----------------------------------------------------------------------------
`ifndef RING_BYTE_BUFFER_CORE_MACROS_SVH
`define RING_BYTE_BUFFER_CORE_MACROS_SVH

// antecedent and consequent in the same cycle
`define RBB_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent in the cycle after the antecedent
`define RBB_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/rbb_pkg.sv]
// ----------------------------------------------------------------------------
// rbb_pkg
// Types and constants shared by the ring byte buffer core.
// ----------------------------------------------------------------------------
package rbb_pkg;

   localparam int DEPTH  = 1024;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = 11;
   localparam int SUM_W  = CNT_W + 1;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_PEEK    = 2'd1;
   localparam logic [1:0] OP_ADVANCE = 2'd2;

   typedef struct packed {
      logic [1:0]       operation;
      logic [7:0]       data_byte;
      logic [CNT_W-1:0] amount;
   } req_type;

   typedef struct packed {
      logic [7:0]       read_byte;
      logic             hit;
      logic [CNT_W-1:0] done_count;
      logic [CNT_W-1:0] level;
      logic             is_full;
   } rsp_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic calc;
      logic access;
   } cmd_type;

endpackage

[hdl/ring_byte_buffer_core.sv]
// ----------------------------------------------------------------------------
// ring_byte_buffer_core
// Circular byte FIFO with peek at offset, advance and set-capacity register.
// ----------------------------------------------------------------------------
//  channel   ports                      handshake
//  request   start, busy, req_payload   taken when start && !busy
//  response  rsp_valid, rsp_payload     one-cycle strobe, never stalled
//  config    csr_we, csr_wdata          written when csr_we, write only
//
//  Each transaction runs in order through accept, address add-and-wrap, store
//  access (single-port 1024 x 8 memory, registered read), response strobe.
//  busy stays high from acceptance until the response cycle ends.
//  Synchronous reset: empty buffer, head 0, capacity 1024; no clearing pass.
//  The response has no back-pressure; it is shown for one cycle only.
// ----------------------------------------------------------------------------
`include "ring_byte_buffer_core_macros.svh"

module ring_byte_buffer_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  rbb_pkg::req_type          req_payload,
   output logic                      rsp_valid,
   output rbb_pkg::rsp_type          rsp_payload,
   input  logic                      csr_we,
   input  logic [rbb_pkg::CNT_W-1:0] csr_wdata
);
   import rbb_pkg::*;

   cmd_type cmd;

   rbb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   rbb_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .rsp_payload (rsp_payload)
   );

   `RBB_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_valid, "accepted transaction did not raise busy")
   `RBB_ASSERT_NEXT(a_reply_idle, clock, reset, rsp_valid, !busy && !rsp_valid, "response not followed by idle")
   `RBB_ASSERT_SAME(a_level_range, clock, reset, rsp_valid, rsp_payload.level <= DEPTH_CNT, "level above depth")
   `RBB_ASSERT_SAME(a_byte_needs_hit, clock, reset, rsp_valid && (rsp_payload.read_byte != 8'd0), rsp_payload.hit, "read byte without hit")
   `RBB_ASSERT_SAME(a_full_nonempty, clock, reset, rsp_valid && rsp_payload.is_full, rsp_payload.level != '0, "full flag with empty buffer")

endmodule

[hdl/rbb_ctrl.sv]
// ----------------------------------------------------------------------------
// rbb_ctrl
// Sequencer: accept, compute address, access store, present result.
// ----------------------------------------------------------------------------
module rbb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_valid,
   output rbb_pkg::cmd_type cmd
);
   import rbb_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CALC   = 4'b0010,
      ST_ACCESS = 4'b0100,
      ST_REPLY  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (start) state_in = ST_CALC;
         ST_CALC:   state_in = ST_ACCESS;
         ST_ACCESS: state_in = ST_REPLY;
         ST_REPLY:  state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_valid  = (state_ff == ST_REPLY);
   assign cmd.load   = (state_ff == ST_IDLE) && start;
   assign cmd.calc   = (state_ff == ST_CALC);
   assign cmd.access = (state_ff == ST_ACCESS);

endmodule

[hdl/rbb_datapath.sv]
// ----------------------------------------------------------------------------
// rbb_datapath
// Byte store, head/occupancy/capacity registers and result formation.
// ----------------------------------------------------------------------------
module rbb_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  rbb_pkg::cmd_type             cmd,
   input  rbb_pkg::req_type             req_payload,
   input  logic                         csr_we,
   input  logic [rbb_pkg::CNT_W-1:0]    csr_wdata,
   output rbb_pkg::rsp_type             rsp_payload
);
   import rbb_pkg::*;

   logic [7:0]        mem [DEPTH];

   req_type           req_ff;
   logic [ADDR_W-1:0] head_ff;
   logic [CNT_W-1:0]  occ_ff;
   logic [CNT_W-1:0]  cap_ff;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              hit_ff, hit_in;
   logic [CNT_W-1:0]  done_ff, done_in;
   logic [7:0]        rd_ff;

   logic [CNT_W-1:0]  adv_n;
   logic [CNT_W-1:0]  offset;
   logic [SUM_W-1:0]  sum;
   logic [SUM_W-1:0]  wrapped;
   logic [CNT_W-1:0]  cap_clamped;

   always_comb begin
      if (csr_wdata == '0) begin
         cap_clamped = CNT_W'(1);
      end else if (csr_wdata > DEPTH_CNT) begin
         cap_clamped = DEPTH_CNT;
      end else begin
         cap_clamped = csr_wdata;
      end
   end

   // for writes, advances and peek hits sum stays below twice the capacity, so one conditional subtract wraps it
   always_comb begin
      adv_n = (req_ff.amount < occ_ff) ? req_ff.amount : occ_ff;
      case (req_ff.operation)
         OP_WRITE:   offset = occ_ff;
         OP_ADVANCE: offset = adv_n;
         default:    offset = req_ff.amount;
      endcase
      sum     = SUM_W'(head_ff) + SUM_W'(offset);
      wrapped = (sum >= SUM_W'(cap_ff)) ? (sum - SUM_W'(cap_ff)) : sum;
      addr_in = wrapped[ADDR_W-1:0];
   end

   always_comb begin
      hit_in  = 1'b0;
      done_in = '0;
      case (req_ff.operation)
         OP_WRITE: begin
            hit_in  = (occ_ff < cap_ff);
            done_in = CNT_W'(occ_ff < cap_ff);
         end
         OP_PEEK: begin
            hit_in = (req_ff.amount < occ_ff);
         end
         OP_ADVANCE: begin
            done_in = adv_n;
         end
         default: begin
            hit_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_payload;
      end
      if (cmd.calc) begin
         addr_ff <= addr_in;
         hit_ff  <= hit_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         occ_ff  <= '0;
         cap_ff  <= DEPTH_CNT;
      end else if (csr_we) begin
         head_ff <= '0;
         occ_ff  <= '0;
         cap_ff  <= cap_clamped;
      end else if (cmd.access) begin
         if ((req_ff.operation == OP_WRITE) && hit_ff) begin
            occ_ff <= occ_ff + CNT_W'(1);
         end else if (req_ff.operation == OP_ADVANCE) begin
            head_ff <= addr_ff;
            occ_ff  <= occ_ff - done_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.access) begin
         if ((req_ff.operation == OP_WRITE) && hit_ff) begin
            mem[addr_ff] <= req_ff.data_byte;
         end
         rd_ff <= mem[addr_ff];
      end
   end

   always_comb begin
      rsp_payload.read_byte  = ((req_ff.operation == OP_PEEK) && hit_ff) ? rd_ff : 8'd0;
      rsp_payload.hit        = hit_ff;
      rsp_payload.done_count = done_ff;
      rsp_payload.level      = occ_ff;
      rsp_payload.is_full    = (occ_ff == cap_ff);
   end

endmodule

[tb/tb_ring_byte_buffer_core.sv]
// ----------------------------------------------------------------------------
// tb_ring_byte_buffer_core
// Self-checking bench for the ring byte buffer core. A behavioural mirror of
// the buffer (store, head, level, capacity) predicts every response; the
// responses are compared field by field in order. Directed corner cases come
// first, then a full-depth fill with wrap, then random traffic over a range
// of capacity settings, with random gaps on the request side.
// ----------------------------------------------------------------------------
module tb_ring_byte_buffer_core;
   import rbb_pkg::*;

   localparam logic [1:0] OP_UNKNOWN     = 2'd3;
   localparam int         WATCHDOG_LIMIT = 2000;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             start       = 1'b0;
   logic             busy;
   req_type          req_payload = '0;
   logic             rsp_valid;
   rsp_type          rsp_payload;
   logic             csr_we      = 1'b0;
   logic [CNT_W-1:0] csr_wdata   = '0;

   // mirror of the buffer state
   logic [7:0]        byte_image [DEPTH];
   logic [ADDR_W-1:0] mirror_head;
   logic [CNT_W-1:0]  mirror_level;
   logic [CNT_W-1:0]  mirror_capacity;

   rsp_type pending_rsp [$];
   bit      gaps_on = 1'b1;
   int      quiet_cycles = 0;
   int      n_sent = 0;
   int      n_checked = 0;
   int      n_cap_writes = 0;
   int      n_errors = 0;

   ring_byte_buffer_core DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int wrap_slot(input int idx);
      if (idx >= int'(mirror_capacity))
         idx -= int'(mirror_capacity);
      return idx;
   endfunction

   function automatic rsp_type predict_buffer_op(input req_type item);
      rsp_type res;
      int      n;
      res = '0;
      case (item.operation)
         OP_WRITE: begin
            if (mirror_level < mirror_capacity) begin
               byte_image[wrap_slot(int'(mirror_head) + int'(mirror_level))] = item.data_byte;
               mirror_level = mirror_level + CNT_W'(1);
               res.hit        = 1'b1;
               res.done_count = CNT_W'(1);
            end
         end
         OP_PEEK: begin
            if (item.amount < mirror_level) begin
               res.read_byte = byte_image[wrap_slot(int'(mirror_head) + int'(item.amount))];
               res.hit       = 1'b1;
            end
         end
         OP_ADVANCE: begin
            n = (item.amount < mirror_level) ? int'(item.amount) : int'(mirror_level);
            mirror_head    = ADDR_W'(wrap_slot(int'(mirror_head) + n));
            mirror_level   = mirror_level - CNT_W'(n);
            res.done_count = CNT_W'(n);
         end
         default: ;
      endcase
      res.level   = mirror_level;
      res.is_full = (mirror_level == mirror_capacity);
      return res;
   endfunction

   function automatic req_type make_req(input logic [1:0] op, input int data, input int amt);
      req_type r;
      r.operation = op;
      r.data_byte = 8'(data);
      r.amount    = CNT_W'(amt);
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      if (!gaps_on)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // mostly well-formed: offsets and counts near the current level
   function automatic req_type random_req(input int write_pct);
      req_type r;
      int      roll;
      roll = $urandom_range(0, 99);
      r = make_req(OP_UNKNOWN, $urandom_range(0, 255), $urandom_range(0, 2047));
      if (roll < write_pct) begin
         r.operation = OP_WRITE;
      end else if (roll < write_pct + (95 - write_pct) / 2) begin
         r.operation = OP_PEEK;
         if ($urandom_range(0, 9) < 8)
            r.amount = CNT_W'($urandom_range(0, int'(mirror_level) + 1));
      end else if (roll < 95) begin
         r.operation = OP_ADVANCE;
         if ($urandom_range(0, 9) < 8)
            r.amount = CNT_W'($urandom_range(0, int'(mirror_level) + 2));
      end
      return r;
   endfunction

   // called at a clock edge; returns at the edge that accepts the transaction, or after the random gap that follows it
   task automatic send_item(input req_type item);
      int gap;
      gap = pick_gap();
      start       <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (busy);
      pending_rsp.push_back(predict_buffer_op(item));
      n_sent++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_rsp.size() != 0 || busy)
         @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CNT_W-1:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (value == '0)
         mirror_capacity = CNT_W'(1);
      else if (value > DEPTH_CNT)
         mirror_capacity = DEPTH_CNT;
      else
         mirror_capacity = value;
      mirror_head  = '0;
      mirror_level = '0;
      n_cap_writes++;
   endtask

   // reset state, each operation, peek misses, unknown opcode
   task automatic test_basic_ops();
      send_item(make_req(OP_PEEK, 0, 0));
      send_item(make_req(OP_ADVANCE, 0, 5));
      send_item(make_req(OP_UNKNOWN, 255, 2047));
      send_item(make_req(OP_WRITE, 8'h00, 0));
      send_item(make_req(OP_WRITE, 8'hFF, 2047));
      send_item(make_req(OP_WRITE, 8'h5A, 0));
      send_item(make_req(OP_PEEK, 0, 0));
      send_item(make_req(OP_PEEK, 0, 2));
      send_item(make_req(OP_PEEK, 0, 3));
      send_item(make_req(OP_PEEK, 255, 2047));
      send_item(make_req(OP_ADVANCE, 0, 1));
      send_item(make_req(OP_PEEK, 0, 0));
      send_item(make_req(OP_ADVANCE, 255, 2047));
   endtask

   // capacity of one, zero taken as one, oversize taken as full depth
   task automatic test_capacity_limits();
      write_capacity(CNT_W'(1));
      send_item(make_req(OP_WRITE, 8'hA5, 0));
      send_item(make_req(OP_WRITE, 8'h3C, 0));
      send_item(make_req(OP_PEEK, 0, 0));
      send_item(make_req(OP_ADVANCE, 0, 0));
      send_item(make_req(OP_ADVANCE, 0, 1));
      send_item(make_req(OP_PEEK, 0, 0));
      write_capacity(CNT_W'(0));
      send_item(make_req(OP_WRITE, 8'h81, 0));
      send_item(make_req(OP_WRITE, 8'h7E, 0));
      write_capacity(CNT_W'(2047));
      send_item(make_req(OP_UNKNOWN, 0, 0));
      send_item(make_req(OP_PEEK, 0, 0));
   endtask

   // fill all 1024 bytes from an offset head, then wrap the head past the top
   task automatic test_full_depth_wrap();
      write_capacity(DEPTH_CNT);
      repeat (10) send_item(make_req(OP_WRITE, $urandom_range(0, 255), 0));
      send_item(make_req(OP_ADVANCE, 0, 10));
      while (mirror_level < mirror_capacity) begin
         if ($urandom_range(0, 9) == 0)
            send_item(make_req(OP_PEEK, 0, $urandom_range(0, int'(mirror_level))));
         else
            send_item(make_req(OP_WRITE, $urandom_range(0, 255), 0));
      end
      send_item(make_req(OP_WRITE, 8'h11, 0));
      send_item(make_req(OP_PEEK, 0, 1023));
      send_item(make_req(OP_PEEK, 0, 1024));
      send_item(make_req(OP_ADVANCE, 0, 1013));
      repeat (5) send_item(make_req(OP_WRITE, $urandom_range(0, 255), 0));
      for (int off = 9; off < 17; off++)
         send_item(make_req(OP_PEEK, 0, off));
      send_item(make_req(OP_ADVANCE, 0, 2047));
   endtask

   task automatic test_random_traffic();
      int caps [12];
      int write_pct;
      caps = '{2, 3, 1, 7, 16, 0, 33, $urandom_range(2, 64),
               $urandom_range(65, 1023), 2047, 1500, 5};
      foreach (caps[i]) begin
         write_capacity(CNT_W'(caps[i]));
         gaps_on   = ($urandom_range(0, 3) != 0);
         write_pct = $urandom_range(30, 70);
         repeat (55) send_item(random_req(write_pct));
      end
      gaps_on = 1'b1;
   endtask

   // response checker
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $error("response with no transaction outstanding");
            n_errors++;
         end else begin
            want = pending_rsp.pop_front();
            n_checked++;
            if (rsp_payload.read_byte !== want.read_byte) begin
               $error("read_byte: expected %0d, got %0d", want.read_byte, rsp_payload.read_byte);
               n_errors++;
            end
            if (rsp_payload.hit !== want.hit) begin
               $error("hit: expected %0d, got %0d", want.hit, rsp_payload.hit);
               n_errors++;
            end
            if (rsp_payload.done_count !== want.done_count) begin
               $error("done_count: expected %0d, got %0d", want.done_count,
                      rsp_payload.done_count);
               n_errors++;
            end
            if (rsp_payload.level !== want.level) begin
               $error("level: expected %0d, got %0d", want.level, rsp_payload.level);
               n_errors++;
            end
            if (rsp_payload.is_full !== want.is_full) begin
               $error("is_full: expected %0d, got %0d", want.is_full, rsp_payload.is_full);
               n_errors++;
            end
         end
      end
   end

   // watchdog on cycles with no transaction, response or register write
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("ring_byte_buffer_core: mismatch");
         $finish;
      end
   end

   initial begin
      mirror_head     = '0;
      mirror_level    = '0;
      mirror_capacity = DEPTH_CNT;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_ops();
      test_capacity_limits();
      test_full_depth_wrap();
      test_random_traffic();

      wait_idle();
      repeat (8) @(posedge clock);
      $display("%0d transactions sent, %0d responses compared, %0d capacity settings",
               n_sent, n_checked, n_cap_writes);
      $display("covered: full depth with wrap, capacities 1..1024 incl. clamped values");
      if (n_errors == 0)
         $display("ring_byte_buffer_core: match");
      else
         $display("ring_byte_buffer_core: mismatch");
      $finish;
   end

endmodule
